// ===== sv/rss_pkg.sv =====
// ----------------------------------------------------------------------------
// Rotated sprite sampler package
// Shared constants, types and address helpers for the sprite sampler.
// ----------------------------------------------------------------------------
package rss_pkg;

  localparam int MAX_COLS = 256;
  localparam int MAX_ROWS = 256;

  localparam int DEPTH  = MAX_ROWS * MAX_COLS;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CW     = $clog2(MAX_COLS);
  localparam int RIW    = $clog2(MAX_ROWS);
  localparam int EW     = $clog2(MAX_COLS + 1);
  localparam int RW     = $clog2(MAX_ROWS + 1);
  localparam int NW     = ((CW > 8) ? CW : 8) + 1;

  localparam int IN_TDATA_W  = 32;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 8;
  localparam int OUT_TUSER_W = 1;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 32;

  localparam logic [8:0]  RESET_WIDTH  = 9'd256;
  localparam logic [8:0]  RESET_HEIGHT = 9'd256;
  localparam logic [7:0]  RESET_KEY    = 8'd254;
  localparam logic [31:0] RESET_COS    = 32'h0001_0000;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_LOAD   = 2'd1,
    OP_SAMPLE = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    REG_SPRITE_WIDTH  = 3'd0,
    REG_SPRITE_HEIGHT = 3'd1,
    REG_TRANS_KEY     = 3'd2,
    REG_MIRROR_MODE   = 3'd3,
    REG_ORIGIN_U      = 3'd4,
    REG_ORIGIN_V      = 3'd5,
    REG_COS_STEP      = 3'd6,
    REG_SIN_STEP      = 3'd7
  } reg_idx_t;

  typedef enum logic [1:0] {
    MOP_XC = 2'd0,
    MOP_YS = 2'd1,
    MOP_XS = 2'd2,
    MOP_YC = 2'd3
  } mul_op_t;

  typedef enum logic [2:0] {
    ACC_NONE   = 3'd0,
    ACC_U_INIT = 3'd1,
    ACC_U_ADD  = 3'd2,
    ACC_V_INIT = 3'd3,
    ACC_V_ADD  = 3'd4
  } acc_op_t;

  typedef struct packed {
    logic [8:0]         sprite_width;
    logic [8:0]         sprite_height;
    logic [7:0]         trans_key;
    logic               mirror_mode;
    logic signed [31:0] origin_u;
    logic signed [31:0] origin_v;
    logic signed [31:0] cos_step;
    logic signed [31:0] sin_step;
  } cfg_t;

  typedef struct packed {
    logic    cap_item;
    logic    clr_start;
    logic    clr_step;
    logic    load_en;
    logic    mul_en;
    mul_op_t mul_op;
    acc_op_t acc_op;
    logic    addr_en;
    logic    out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic clr_done;
    logic out_free;
  } dp_sts_t;

  function automatic logic [EW-1:0] eff_width(input logic [8:0] v);
    logic [EW-1:0] r;
    if (v == 9'd0) begin
      r = EW'(1);
    end else if (32'(v) > MAX_COLS) begin
      r = EW'(MAX_COLS);
    end else begin
      r = EW'(v);
    end
    return r;
  endfunction

  function automatic logic [RW-1:0] eff_height(input logic [8:0] v);
    logic [RW-1:0] r;
    if (v == 9'd0) begin
      r = RW'(1);
    end else if (32'(v) > MAX_ROWS) begin
      r = RW'(MAX_ROWS);
    end else begin
      r = RW'(v);
    end
    return r;
  endfunction

  function automatic logic [ADDR_W-1:0] make_addr(input logic [RIW-1:0] row,
                                                   input logic [CW-1:0] col);
    return ADDR_W'(ADDR_W'(row) * ADDR_W'(MAX_COLS)) + ADDR_W'(col);
  endfunction

endpackage

// ===== sv/rss_regs.sv =====
// ----------------------------------------------------------------------------
// Sprite sampler configuration registers
// Holds the eight configuration registers written through the write channel.
// ----------------------------------------------------------------------------
module rss_regs (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [rss_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rss_pkg::CFG_DATA_W-1:0] cfg_data,
  output rss_pkg::cfg_t                cfg
);
  import rss_pkg::*;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sprite_width  <= RESET_WIDTH;
      cfg.sprite_height <= RESET_HEIGHT;
      cfg.trans_key     <= RESET_KEY;
      cfg.mirror_mode   <= 1'b0;
      cfg.origin_u      <= '0;
      cfg.origin_v      <= '0;
      cfg.cos_step      <= RESET_COS;
      cfg.sin_step      <= '0;
    end else if (cfg_valid) begin
      unique case (reg_idx_t'(cfg_index))
        REG_SPRITE_WIDTH:  cfg.sprite_width  <= cfg_data[8:0];
        REG_SPRITE_HEIGHT: cfg.sprite_height <= cfg_data[8:0];
        REG_TRANS_KEY:     cfg.trans_key     <= cfg_data[7:0];
        REG_MIRROR_MODE:   cfg.mirror_mode   <= cfg_data[0];
        REG_ORIGIN_U:      cfg.origin_u      <= cfg_data;
        REG_ORIGIN_V:      cfg.origin_v      <= cfg_data;
        REG_COS_STEP:      cfg.cos_step      <= cfg_data;
        REG_SIN_STEP:      cfg.sin_step      <= cfg_data;
        default: begin
        end
      endcase
    end
  end

endmodule

// ===== sv/rss_ctrl.sv =====
// ----------------------------------------------------------------------------
// Sprite sampler controller
// Sequences store clearing, stream loading and the multi-cycle sample path.
// ----------------------------------------------------------------------------
module rss_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [rss_pkg::IN_TUSER_W-1:0] opcode,
  input  rss_pkg::dp_sts_t              sts,
  output rss_pkg::dp_cmd_t              cmd
);
  import rss_pkg::*;

  typedef enum logic [10:0] {
    ST_IDLE  = 11'b000_0000_0001,
    ST_CLEAR = 11'b000_0000_0010,
    ST_LOAD  = 11'b000_0000_0100,
    ST_MUL0  = 11'b000_0000_1000,
    ST_MUL1  = 11'b000_0001_0000,
    ST_MUL2  = 11'b000_0010_0000,
    ST_MUL3  = 11'b000_0100_0000,
    ST_MUL4  = 11'b000_1000_0000,
    ST_ADDR  = 11'b001_0000_0000,
    ST_READ  = 11'b010_0000_0000,
    ST_OUT   = 11'b100_0000_0000
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;

  always_comb begin
    state_next   = state;
    cmd          = '0;
    cmd.mul_op   = MOP_XC;
    cmd.acc_op   = ACC_NONE;
    cmd.cap_item = accept;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          case (op_t'(opcode))
            OP_CLEAR: begin
              cmd.clr_start = 1'b1;
              state_next    = ST_CLEAR;
            end
            OP_LOAD:   state_next = ST_LOAD;
            OP_SAMPLE: state_next = ST_MUL0;
            default:   state_next = ST_IDLE;
          endcase
        end
      end
      ST_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_done) begin
          state_next = ST_IDLE;
        end
      end
      ST_LOAD: begin
        cmd.load_en = 1'b1;
        state_next  = ST_IDLE;
      end
      ST_MUL0: begin
        cmd.mul_en = 1'b1;
        cmd.mul_op = MOP_XC;
        state_next = ST_MUL1;
      end
      ST_MUL1: begin
        cmd.mul_en = 1'b1;
        cmd.mul_op = MOP_YS;
        cmd.acc_op = ACC_U_INIT;
        state_next = ST_MUL2;
      end
      ST_MUL2: begin
        cmd.mul_en = 1'b1;
        cmd.mul_op = MOP_XS;
        cmd.acc_op = ACC_U_ADD;
        state_next = ST_MUL3;
      end
      ST_MUL3: begin
        cmd.mul_en = 1'b1;
        cmd.mul_op = MOP_YC;
        cmd.acc_op = ACC_V_INIT;
        state_next = ST_MUL4;
      end
      ST_MUL4: begin
        cmd.acc_op = ACC_V_ADD;
        state_next = ST_ADDR;
      end
      ST_ADDR: begin
        cmd.addr_en = 1'b1;
        state_next  = ST_READ;
      end
      ST_READ: begin
        state_next = ST_OUT;
      end
      ST_OUT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  assert property (@(posedge clk) $past(rst) |-> state == ST_CLEAR)
    else $error("Store clearing pass does not follow reset.");

  assert property (@(posedge clk) disable iff (rst)
    (state == ST_CLEAR && !sts.clr_done) |=> state == ST_CLEAR)
    else $error("Clearing pass left before the last entry.");

  assert property (@(posedge clk) disable iff (rst)
    (state == ST_OUT && !sts.out_free) |=> state == ST_OUT)
    else $error("Sample result dropped while the output was stalled.");

endmodule

// ===== sv/rss_datapath.sv =====
// ----------------------------------------------------------------------------
// Sprite sampler datapath
// Sprite store, run-length loader, coordinate multiplier and result register.
// ----------------------------------------------------------------------------
module rss_datapath (
  input  logic              clk,
  input  logic              rst,
  input  rss_pkg::dp_cmd_t  cmd,
  output rss_pkg::dp_sts_t  sts,
  input  rss_pkg::cfg_t     cfg,
  input  logic [7:0]        item_byte,
  input  logic [10:0]       item_dx,
  input  logic [10:0]       item_dy,
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [7:0]        color_index,
  output logic              hit
);
  import rss_pkg::*;

  logic [7:0]        mem [DEPTH];
  logic [7:0]        rd_data;
  logic [ADDR_W-1:0] rd_addr;
  logic              in_sprite;

  logic [ADDR_W-1:0] clr_cnt;
  logic [7:0]        clear_value;

  logic [CW-1:0]     load_column;
  logic [RW-1:0]     load_row;
  logic              run_pending;

  logic [7:0]        byte_q;
  logic [10:0]       dx_q;
  logic [10:0]       dy_q;

  logic [31:0]       prod;
  logic [31:0]       acc_u;
  logic [31:0]       acc_v;

  logic [EW-1:0]     w;
  logic [RW-1:0]     h;

  logic [CW-1:0]     column_next;
  logic [RW-1:0]     load_row_next;
  logic              run_pending_next;
  logic              ld_we;
  logic [ADDR_W-1:0] ld_addr;
  logic [CW-1:0]     c1;
  logic [RW-1:0]     r1;
  logic [NW-1:0]     adv;

  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [7:0]        mem_wdata;

  logic [31:0]       mul_a;
  logic [31:0]       mul_b;

  logic [15:0]       su;
  logic [15:0]       sv;
  logic              in_sprite_next;
  logic [CW-1:0]     col_sel;

  assign w = eff_width(cfg.sprite_width);
  assign h = eff_height(cfg.sprite_height);

  assign sts.clr_done = (clr_cnt == ADDR_W'(DEPTH - 1));
  assign sts.out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (cmd.cap_item) begin
      byte_q <= item_byte;
      dx_q   <= item_dx;
      dy_q   <= item_dy;
    end
  end

  // Run-length loader: one stream byte per load command.
  always_comb begin
    column_next      = load_column;
    load_row_next    = load_row;
    run_pending_next = run_pending;
    ld_we            = 1'b0;
    c1               = load_column;
    r1               = load_row;
    adv              = '0;
    if (load_row < h) begin
      if (EW'(load_column) >= w) begin
        c1 = '0;
        r1 = load_row + RW'(1);
      end
      column_next   = c1;
      load_row_next = r1;
      if (r1 < h) begin
        if (run_pending) begin
          run_pending_next = 1'b0;
          adv              = NW'(c1) + NW'(byte_q);
        end else if (byte_q != cfg.trans_key) begin
          ld_we = 1'b1;
          adv   = NW'(c1) + NW'(1);
        end else begin
          run_pending_next = 1'b1;
        end
        if (!(run_pending == 1'b0 && byte_q == cfg.trans_key)) begin
          if (adv >= NW'(w)) begin
            column_next   = '0;
            load_row_next = r1 + RW'(1);
          end else begin
            column_next = CW'(adv);
          end
        end
      end
    end
    ld_addr = make_addr(RIW'(r1), c1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt     <= '0;
      clear_value <= RESET_KEY;
      load_column <= '0;
      load_row    <= '0;
      run_pending <= 1'b0;
    end else if (cmd.clr_start) begin
      clr_cnt     <= '0;
      clear_value <= cfg.trans_key;
      load_column <= '0;
      load_row    <= '0;
      run_pending <= 1'b0;
    end else begin
      if (cmd.clr_step && !sts.clr_done) begin
        clr_cnt <= clr_cnt + ADDR_W'(1);
      end
      if (cmd.load_en) begin
        load_column <= column_next;
        load_row    <= load_row_next;
        run_pending <= run_pending_next;
      end
    end
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = ld_addr;
    mem_wdata = byte_q;
    if (cmd.clr_step) begin
      mem_we    = 1'b1;
      mem_waddr = clr_cnt;
      mem_wdata = clear_value;
    end else if (cmd.load_en && ld_we) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data <= mem[rd_addr];
  end

  // Shared multiplier; the low 32 bits of each product are kept.
  always_comb begin
    case (cmd.mul_op)
      MOP_XC: begin
        mul_a = 32'(dx_q);
        mul_b = cfg.cos_step;
      end
      MOP_YS: begin
        mul_a = 32'(dy_q);
        mul_b = cfg.sin_step;
      end
      MOP_XS: begin
        mul_a = 32'(dx_q);
        mul_b = cfg.sin_step;
      end
      default: begin
        mul_a = 32'(dy_q);
        mul_b = cfg.cos_step;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod <= mul_a * mul_b;
    end
    case (cmd.acc_op)
      ACC_U_INIT: acc_u <= cfg.origin_u + prod;
      ACC_U_ADD:  acc_u <= acc_u + prod;
      ACC_V_INIT: acc_v <= cfg.origin_v - prod;
      ACC_V_ADD:  acc_v <= acc_v + prod;
      default: begin
      end
    endcase
  end

  always_comb begin
    su             = acc_u[31:16];
    sv             = acc_v[31:16];
    in_sprite_next = (su < 16'(w)) && (sv < 16'(h));
    if (cfg.mirror_mode) begin
      col_sel = CW'(w - EW'(1) - EW'(su));
    end else begin
      col_sel = CW'(su);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.addr_en) begin
      rd_addr   <= make_addr(RIW'(sv), col_sel);
      in_sprite <= in_sprite_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      color_index <= in_sprite ? rd_data : 8'd0;
      hit         <= in_sprite && (rd_data != cfg.trans_key);
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(cmd.out_load))
    else $error("Result appeared without a load of the output register.");

  assert property (@(posedge clk) disable iff (rst)
    32'(load_row) <= MAX_ROWS)
    else $error("Load row ran past the store.");

  assert property (@(posedge clk) disable iff (rst)
    32'(load_column) < MAX_COLS)
    else $error("Load column ran past the store.");

endmodule

// ===== sv/rotated_sprite_sampler_unit.sv =====
// ----------------------------------------------------------------------------
// Rotated sprite sampler
// Sprite store loaded from a run-length stream and sampled along a rotated grid.
// ----------------------------------------------------------------------------
// A sample item runs through the multiply, address, read and output states,
// using the single shared multiplier four times; the next item is taken
// in the cycle after the result register is loaded, which waits while the
// output is stalled. A clear item and reset both start a clearing pass
// over all MAX_ROWS * MAX_COLS (65536) store entries, one per cycle, during
// which no item is accepted; configuration writes are taken.
module rotated_sprite_sampler_unit (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // data_byte [7:0], dest_x [18:8], dest_y [29:19], zero fill above.
  input  logic [rss_pkg::IN_TDATA_W-1:0]  s_tdata,
  // opcode [1:0].
  input  logic [rss_pkg::IN_TUSER_W-1:0]  s_tuser,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // color_index [7:0].
  output logic [rss_pkg::OUT_TDATA_W-1:0] m_tdata,
  // hit [0].
  output logic [rss_pkg::OUT_TUSER_W-1:0] m_tuser,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [rss_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rss_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import rss_pkg::*;

  cfg_t    cfg;
  dp_cmd_t cmd;
  dp_sts_t sts;
  logic    hit;

  rss_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  rss_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .opcode   (s_tuser),
    .sts      (sts),
    .cmd      (cmd)
  );

  rss_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .cfg         (cfg),
    .item_byte   (s_tdata[7:0]),
    .item_dx     (s_tdata[18:8]),
    .item_dy     (s_tdata[29:19]),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .color_index (m_tdata),
    .hit         (hit)
  );

  assign m_tuser = OUT_TUSER_W'(hit);

endmodule
